// ----- design/box_chunk_splitter_macros.svh -----
// Assertion macros shared by the box chunk splitter RTL.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef BOX_CHUNK_SPLITTER_MACROS_SVH
`define BOX_CHUNK_SPLITTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BCS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/bcs_pkg.sv -----
// Shared types, constants and small arithmetic helpers for the box chunk splitter.
// No dependencies; the controller, the datapath and the top module import this package.
`timescale 1ns / 1ps

package bcs_pkg;

    // Upper bound on the chunk count of one request.
    localparam logic [6:0] CHUNK_CAP = 7'd64;

    // Near-square window: 361*e0^2 < 400*area < 441*e0^2.
    localparam int unsigned NEAR_LO  = 361;
    localparam int unsigned NEAR_MID = 400;
    localparam int unsigned NEAR_HI  = 441;

    // Controller states.
    typedef enum logic [4:0] {
        S_IDLE,
        S_DIV_GO,
        S_DIV_WAIT,
        S_AFTER_M,
        S_NEAR_A,
        S_NEAR_B,
        S_NEAR_C,
        S_NEAR_D,
        S_NEAR_E,
        S_NEAR_F,
        S_FSTEP,
        S_PAIR,
        S_TIE,
        S_RES,
        S_SETC,
        S_CHECK,
        S_MUL,
        S_REM,
        S_EMIT_INIT,
        S_EMIT,
        S_EMPTY
    } state_t;

    // Datapath operations.
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_DIV_GO,
        OP_DIV_WAIT,
        OP_NEAR_A,
        OP_NEAR_B,
        OP_NEAR_C,
        OP_NEAR_D,
        OP_NEAR_E,
        OP_NEAR_F,
        OP_FSTEP,
        OP_PAIR,
        OP_RES,
        OP_SETC,
        OP_MUL,
        OP_REM,
        OP_EMIT_INIT,
        OP_EMIT,
        OP_EMPTY
    } op_t;

    // Divider operand selection and result destination.
    typedef enum logic [2:0] {
        DS_M,
        DS_SA,
        DS_SB,
        DS_IDEAL,
        DS_Q,
        DS_R
    } dsel_t;

    typedef struct packed {
        op_t   op;
        dsel_t dsel;
        logic  dim;
    } cmd_t;

    typedef struct packed {
        logic req_valid;
        logic div_done;
        logic func;
        logic n_zero;
        logic need_sums;
        logic search_done;
        logic fstep_more;
        logic c_zero;
        logic out_free;
        logic emit_last;
    } sts_t;

    // Largest f with f*f <= n, for n up to 64 (at least 1).
    function automatic logic [3:0] isqrt_small(input logic [6:0] n);
        logic [3:0] f;
        f = 4'd1;
        for (int k = 2; k <= 8; k++) begin
            if (7'(k * k) <= n) begin
                f = 4'(k);
            end
        end
        return f;
    endfunction

    // Quotient n / f for a small factor f in 1..8 and n up to 64.
    // Odd factors use a scaled reciprocal that is exact over that range.
    function automatic logic [6:0] div_small(input logic [6:0] n, input logic [3:0] f);
        logic [16:0] p;
        logic [6:0]  q;
        p = 17'd0;
        unique case (f)
            4'd1:    q = n;
            4'd2:    q = {1'b0, n[6:1]};
            4'd3:
            begin
                p = {10'b0, n} * 17'd43;
                q = p[13:7];
            end
            4'd4:    q = {2'b0, n[6:2]};
            4'd5:
            begin
                p = {10'b0, n} * 17'd205;
                q = p[16:10];
            end
            4'd6:
            begin
                p = {10'b0, n} * 17'd43;
                q = p[14:8];
            end
            4'd7:
            begin
                p = {10'b0, n} * 17'd37;
                q = p[14:8];
            end
            4'd8:    q = {3'b0, n[6:3]};
            default: q = 7'd0;
        endcase
        return q;
    endfunction

    // Remainder n % f for a small factor f in 1..8, from the quotient above.
    function automatic logic [2:0] mod_small(input logic [6:0] n, input logic [3:0] f);
        logic [6:0] q;
        logic [6:0] r;
        q = div_small(n, f);
        r = (f > 4'd1) ? (n - 7'(q * {3'b0, f})) : 7'd0;
        return r[2:0];
    endfunction

    // Minimum of a small count and a 32-bit limit.
    function automatic logic [6:0] min7(input logic [6:0] x, input logic [31:0] m);
        return (m < {25'b0, x}) ? m[6:0] : x;
    endfunction

endpackage

// ----- design/bcs_ifs.sv -----
// Valid/ready channel interfaces for requests and chunk results.
// No dependencies.
`timescale 1ns / 1ps

interface bcs_req_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [31:0] origin0;
    logic [31:0] origin1;
    logic [31:0] extent0;
    logic [31:0] extent1;
    logic [31:0] extent2;
    logic [31:0] gran0;
    logic [31:0] gran1;

    modport source (
        output valid, func, origin0, origin1, extent0, extent1, extent2, gran0, gran1,
        input  ready
    );
    modport sink (
        input  valid, func, origin0, origin1, extent0, extent1, extent2, gran0, gran1,
        output ready
    );
endinterface

interface bcs_chunk_if;
    logic        valid;
    logic        ready;
    logic [31:0] chunk_lo0;
    logic [31:0] chunk_hi0;
    logic [31:0] chunk_lo1;
    logic [31:0] chunk_hi1;
    logic        empty_res;
    logic        last;

    modport source (
        output valid, chunk_lo0, chunk_hi0, chunk_lo1, chunk_hi1, empty_res, last,
        input  ready
    );
    modport sink (
        input  valid, chunk_lo0, chunk_hi0, chunk_lo1, chunk_hi1, empty_res, last,
        output ready
    );
endinterface

// ----- design/bcs_div.sv -----
// Iterative restoring divider, one quotient bit per cycle, 32-bit operands.
// Depends on nothing; used by the datapath for every 32-bit division.
`timescale 1ns / 1ps

module bcs_div (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [31:0] divisor,
    output logic        done,
    output logic [31:0] quotient
);

    logic [32:0] rem_reg;
    logic [31:0] quo_reg;
    logic [31:0] dvs_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;

    logic [32:0] shifted;
    logic [32:0] diff;
    logic        ge;

    // Trial subtraction for the current bit.
    always_comb
    begin
        shifted = {rem_reg[31:0], quo_reg[31]};
        diff    = shifted - {1'b0, dvs_reg};
        ge      = shifted >= {1'b0, dvs_reg};
    end

    // Iteration control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 6'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= 6'd32;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Partial remainder and quotient shift register.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= 33'd0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff : shifted;
            quo_reg <= {quo_reg[30:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ----- design/bcs_ctrl.sv -----
// Controller state machine that sequences the splitter datapath.
// Depends on bcs_pkg for the state, command and status types.
`timescale 1ns / 1ps

module bcs_ctrl
    import bcs_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;
    dsel_t  dsel_reg, dsel_next;
    logic   dim_reg, dim_next;

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        dsel_next  = dsel_reg;
        dim_next   = dim_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (sts.req_valid)
                begin
                    state_next = S_DIV_GO;
                    dsel_next  = DS_M;
                    dim_next   = 1'b0;
                end
            end
            S_DIV_GO:
                state_next = S_DIV_WAIT;
            S_DIV_WAIT:
            begin
                if (sts.div_done)
                begin
                    unique case (dsel_reg)
                        DS_M:
                        begin
                            if (!dim_reg)
                            begin
                                state_next = S_DIV_GO;
                                dim_next   = 1'b1;
                            end
                            else
                            begin
                                state_next = S_AFTER_M;
                            end
                        end
                        DS_SA:
                        begin
                            state_next = S_DIV_GO;
                            if (!dim_reg)
                            begin
                                dim_next = 1'b1;
                            end
                            else
                            begin
                                dsel_next = DS_SB;
                                dim_next  = 1'b0;
                            end
                        end
                        DS_SB:
                        begin
                            if (!dim_reg)
                            begin
                                state_next = S_DIV_GO;
                                dim_next   = 1'b1;
                            end
                            else
                            begin
                                state_next = S_RES;
                            end
                        end
                        DS_IDEAL:
                        begin
                            state_next = S_DIV_GO;
                            dsel_next  = DS_Q;
                        end
                        DS_Q:
                            state_next = S_MUL;
                        DS_R:
                        begin
                            if (!dim_reg && sts.func)
                            begin
                                state_next = S_DIV_GO;
                                dsel_next  = DS_IDEAL;
                                dim_next   = 1'b1;
                            end
                            else
                            begin
                                state_next = S_EMIT_INIT;
                            end
                        end
                        default:
                            state_next = S_IDLE;
                    endcase
                end
            end
            S_AFTER_M:
            begin
                if (!sts.func || sts.n_zero)
                begin
                    state_next = S_SETC;
                end
                else
                begin
                    state_next = S_NEAR_A;
                end
            end
            S_NEAR_A:
                state_next = S_NEAR_B;
            S_NEAR_B:
                state_next = S_NEAR_C;
            S_NEAR_C:
                state_next = S_NEAR_D;
            S_NEAR_D:
                state_next = S_NEAR_E;
            S_NEAR_E:
                state_next = S_NEAR_F;
            S_NEAR_F:
                state_next = S_FSTEP;
            S_FSTEP:
            begin
                if (!sts.fstep_more)
                begin
                    state_next = S_PAIR;
                end
            end
            S_PAIR:
                state_next = S_TIE;
            S_TIE:
            begin
                if (sts.need_sums)
                begin
                    state_next = S_DIV_GO;
                    dsel_next  = DS_SA;
                    dim_next   = 1'b0;
                end
                else
                begin
                    state_next = S_RES;
                end
            end
            S_RES:
            begin
                if (sts.search_done)
                begin
                    state_next = S_SETC;
                end
                else
                begin
                    state_next = S_FSTEP;
                end
            end
            S_SETC:
                state_next = S_CHECK;
            S_CHECK:
            begin
                if (sts.c_zero)
                begin
                    state_next = S_EMPTY;
                end
                else
                begin
                    state_next = S_DIV_GO;
                    dsel_next  = DS_IDEAL;
                    dim_next   = 1'b0;
                end
            end
            S_MUL:
                state_next = S_REM;
            S_REM:
            begin
                state_next = S_DIV_GO;
                dsel_next  = DS_R;
            end
            S_EMIT_INIT:
                state_next = S_EMIT;
            S_EMIT:
            begin
                if (sts.out_free && sts.emit_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_EMPTY:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Command outputs.
    always_comb
    begin
        cmd.dsel = dsel_reg;
        cmd.dim  = dim_reg;
        unique case (state_reg)
            S_IDLE:      cmd.op = OP_LOAD;
            S_DIV_GO:    cmd.op = OP_DIV_GO;
            S_DIV_WAIT:  cmd.op = OP_DIV_WAIT;
            S_NEAR_A:    cmd.op = OP_NEAR_A;
            S_NEAR_B:    cmd.op = OP_NEAR_B;
            S_NEAR_C:    cmd.op = OP_NEAR_C;
            S_NEAR_D:    cmd.op = OP_NEAR_D;
            S_NEAR_E:    cmd.op = OP_NEAR_E;
            S_NEAR_F:    cmd.op = OP_NEAR_F;
            S_FSTEP:     cmd.op = OP_FSTEP;
            S_PAIR:      cmd.op = OP_PAIR;
            S_RES:       cmd.op = OP_RES;
            S_SETC:      cmd.op = OP_SETC;
            S_MUL:       cmd.op = OP_MUL;
            S_REM:       cmd.op = OP_REM;
            S_EMIT_INIT: cmd.op = OP_EMIT_INIT;
            S_EMIT:      cmd.op = OP_EMIT;
            S_EMPTY:     cmd.op = OP_EMPTY;
            default:     cmd.op = OP_NONE;
        endcase
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            dsel_reg  <= DS_M;
            dim_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            dsel_reg  <= dsel_next;
            dim_reg   <= dim_next;
        end
    end

endmodule

// ----- design/bcs_datapath.sv -----
// Datapath of the splitter: request latch, factor search, chunk sizing and emission.
// Depends on bcs_pkg, the channel interfaces, bcs_div and the assertion macros.
`timescale 1ns / 1ps
`include "box_chunk_splitter_macros.svh"

module bcs_datapath
    import bcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,
    input  cmd_t        cmd,
    output sts_t        sts,
    bcs_req_if.sink     req,
    bcs_chunk_if.source chunk
);

    // Request and configuration.
    logic [6:0]   nc_reg;
    logic [6:0]   n_reg;
    logic         func_reg;
    logic [31:0]  o_reg [2];
    logic [31:0]  e_reg [2];
    logic [31:0]  g_reg [2];
    logic [31:0]  e2_reg;

    // Search state.
    logic [31:0]  m_reg [2];
    logic [63:0]  prod_reg;
    logic [95:0]  area_reg;
    logic [63:0]  sq_reg;
    logic [104:0] a400_reg;
    logic [72:0]  lo_reg;
    logic [72:0]  hi_reg;
    logic         near_reg;
    logic [3:0]   f_reg;
    logic [6:0]   a_reg [2];
    logic [6:0]   b_reg [2];
    logic [13:0]  n01_reg;
    logic [13:0]  n10_reg;
    logic [31:0]  sa_reg [2];
    logic [31:0]  sb_reg [2];
    logic [6:0]   bc_reg [2];
    logic [13:0]  bprod_reg;

    // Sizing and emission.
    logic [6:0]   c_reg [2];
    logic [31:0]  tmp_reg [2];
    logic [31:0]  sm_reg [2];
    logic [6:0]   nl_reg [2];
    logic [31:0]  big_reg [2];
    logic [6:0]   j_reg;
    logic [6:0]   i_reg;
    logic [31:0]  p_reg [2];

    // Output register.
    logic         out_valid_reg;
    logic [31:0]  out_lo0_reg;
    logic [31:0]  out_hi0_reg;
    logic [31:0]  out_lo1_reg;
    logic [31:0]  out_hi1_reg;
    logic         out_empty_reg;
    logic         out_last_reg;

    logic [6:0]   n_sat;
    logic [6:0]   q_w;
    logic [2:0]   r_w;
    logic         keep;
    logic [6:0]   t0_w;
    logic [6:0]   t1_w;
    logic [13:0]  tprod;
    logic [32:0]  s01;
    logic [32:0]  s10;
    logic [31:0]  div_a;
    logic [31:0]  div_b;
    logic         div_done;
    logic [31:0]  div_q;
    logic [38:0]  smc;
    logic [31:0]  w0;
    logic [31:0]  w1;
    logic         out_free;
    logic         emit_last;
    logic         load_out;
    logic         accept;

    // Shared divider.
    bcs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.op == OP_DIV_GO),
        .dividend (div_a),
        .divisor  (div_b),
        .done     (div_done),
        .quotient (div_q)
    );

    // Divider operand selection.
    always_comb
    begin
        div_a = e_reg[cmd.dim];
        div_b = g_reg[cmd.dim];
        unique case (cmd.dsel)
            DS_M:     div_b = g_reg[cmd.dim];
            DS_SA:    div_b = {25'b0, a_reg[cmd.dim]};
            DS_SB:    div_b = {25'b0, b_reg[cmd.dim]};
            DS_IDEAL: div_b = {25'b0, c_reg[cmd.dim]};
            DS_Q, DS_R:
            begin
                div_a = tmp_reg[cmd.dim];
                div_b = g_reg[cmd.dim];
            end
            default:  div_b = g_reg[cmd.dim];
        endcase
    end

    // Candidate factor pair and tie-break decision.
    always_comb
    begin
        n_sat = (nc_reg > CHUNK_CAP) ? CHUNK_CAP : nc_reg;
        q_w   = div_small(n_reg, f_reg);
        r_w   = mod_small(n_reg, f_reg);
        s01   = {1'b0, sa_reg[0]} + {1'b0, sa_reg[1]};
        s10   = {1'b0, sb_reg[0]} + {1'b0, sb_reg[1]};
        priority if (n01_reg != n10_reg)
        begin
            keep = n01_reg > n10_reg;
        end
        else if (n01_reg == 14'd0)
        begin
            keep = 1'b1;
        end
        else if (near_reg)
        begin
            keep = {3'b0, f_reg} >= q_w;
        end
        else
        begin
            keep = s01 < s10;
        end
        t0_w  = keep ? a_reg[0] : b_reg[0];
        t1_w  = keep ? a_reg[1] : b_reg[1];
        tprod = keep ? n01_reg : n10_reg;
        smc   = {7'b0, sm_reg[cmd.dim]} * {32'b0, c_reg[cmd.dim]};
    end

    // Chunk widths for the current position.
    always_comb
    begin
        w0        = (j_reg < nl_reg[0]) ? big_reg[0] : sm_reg[0];
        w1        = (i_reg < nl_reg[1]) ? big_reg[1] : sm_reg[1];
        emit_last = (j_reg == c_reg[0] - 7'd1) && (i_reg == c_reg[1] - 7'd1);
        out_free  = !out_valid_reg || chunk.ready;
        accept    = (cmd.op == OP_LOAD) && req.valid;
        load_out  = out_free && ((cmd.op == OP_EMIT) || (cmd.op == OP_EMPTY));
    end

    // Status to the controller.
    always_comb
    begin
        sts.req_valid   = req.valid;
        sts.div_done    = div_done;
        sts.func        = func_reg;
        sts.n_zero      = n_reg == 7'd0;
        sts.need_sums   = (n01_reg == n10_reg) && (n01_reg != 14'd0) && !near_reg;
        sts.search_done = (tprod == {7'b0, n_reg}) || (f_reg == 4'd1);
        sts.fstep_more  = (f_reg > 4'd1) && (r_w != 3'd0);
        sts.c_zero      = (c_reg[0] == 7'd0) || (c_reg[1] == 7'd0);
        sts.out_free    = out_free;
        sts.emit_last   = emit_last;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nc_reg        <= 7'd1;
            n_reg         <= 7'd0;
            bprod_reg     <= 14'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                nc_reg <= cfg_wdata;
            end
            if (accept)
            begin
                n_reg     <= n_sat;
                bprod_reg <= 14'd0;
            end
            if ((cmd.op == OP_RES) && (tprod > bprod_reg))
            begin
                bprod_reg <= tprod;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (chunk.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        unique case (cmd.op)
            OP_LOAD:
            begin
                if (req.valid)
                begin
                    func_reg  <= req.func;
                    o_reg[0]  <= req.origin0;
                    o_reg[1]  <= req.origin1;
                    e_reg[0]  <= req.extent0;
                    e_reg[1]  <= req.extent1;
                    e2_reg    <= req.extent2;
                    g_reg[0]  <= req.gran0;
                    g_reg[1]  <= req.gran1;
                    f_reg     <= isqrt_small(n_sat);
                    bc_reg[0] <= 7'd0;
                    bc_reg[1] <= 7'd0;
                end
            end
            OP_DIV_WAIT:
            begin
                if (div_done)
                begin
                    unique case (cmd.dsel)
                        DS_M:
                            m_reg[cmd.dim] <= (g_reg[cmd.dim] == 32'd0) ? 32'd0 : div_q;
                        DS_SA:
                            sa_reg[cmd.dim] <= div_q;
                        DS_SB:
                            sb_reg[cmd.dim] <= div_q;
                        DS_IDEAL, DS_Q:
                            tmp_reg[cmd.dim] <= div_q;
                        DS_R:
                            nl_reg[cmd.dim] <= min7(c_reg[cmd.dim], div_q);
                        default:
                            tmp_reg[cmd.dim] <= div_q;
                    endcase
                end
            end
            OP_NEAR_A:
                prod_reg <= {32'b0, e_reg[0]} * {32'b0, e_reg[1]};
            OP_NEAR_B:
                area_reg <= {32'b0, {32'b0, prod_reg[31:0]} * {32'b0, e2_reg}};
            OP_NEAR_C:
                area_reg <= area_reg
                    + {({32'b0, prod_reg[63:32]} * {32'b0, e2_reg}), 32'b0};
            OP_NEAR_D:
                sq_reg <= {32'b0, e_reg[0]} * {32'b0, e_reg[0]};
            OP_NEAR_E:
            begin
                a400_reg <= {9'b0, area_reg} * 105'(NEAR_MID);
                lo_reg   <= {9'b0, sq_reg} * 73'(NEAR_LO);
                hi_reg   <= {9'b0, sq_reg} * 73'(NEAR_HI);
            end
            OP_NEAR_F:
                near_reg <= ({32'b0, lo_reg} < a400_reg) && (a400_reg < {32'b0, hi_reg});
            OP_FSTEP:
            begin
                if ((f_reg > 4'd1) && (r_w != 3'd0))
                begin
                    f_reg <= f_reg - 4'd1;
                end
            end
            OP_PAIR:
            begin
                a_reg[0] <= min7({3'b0, f_reg}, m_reg[0]);
                a_reg[1] <= min7(q_w, m_reg[1]);
                b_reg[0] <= min7(q_w, m_reg[0]);
                b_reg[1] <= min7({3'b0, f_reg}, m_reg[1]);
                n01_reg  <= min7({3'b0, f_reg}, m_reg[0]) * min7(q_w, m_reg[1]);
                n10_reg  <= min7(q_w, m_reg[0]) * min7({3'b0, f_reg}, m_reg[1]);
            end
            OP_RES:
            begin
                if (tprod > bprod_reg)
                begin
                    bc_reg[0] <= t0_w;
                    bc_reg[1] <= t1_w;
                end
                f_reg <= f_reg - 4'd1;
            end
            OP_SETC:
            begin
                c_reg[0] <= func_reg ? bc_reg[0] : min7(n_reg, m_reg[0]);
                c_reg[1] <= func_reg ? bc_reg[1] : 7'd1;
            end
            OP_MUL:
                sm_reg[cmd.dim] <= tmp_reg[cmd.dim] * g_reg[cmd.dim];
            OP_REM:
                tmp_reg[cmd.dim] <= e_reg[cmd.dim] - smc[31:0];
            OP_EMIT_INIT:
            begin
                p_reg[0]   <= o_reg[0];
                p_reg[1]   <= o_reg[1];
                j_reg      <= 7'd0;
                i_reg      <= 7'd0;
                big_reg[0] <= sm_reg[0] + g_reg[0];
                big_reg[1] <= sm_reg[1] + g_reg[1];
            end
            OP_EMIT:
            begin
                if (out_free)
                begin
                    out_lo0_reg   <= p_reg[0];
                    out_hi0_reg   <= p_reg[0] + w0;
                    out_lo1_reg   <= p_reg[1];
                    out_hi1_reg   <= func_reg ? (p_reg[1] + w1) : (o_reg[1] + e_reg[1]);
                    out_empty_reg <= 1'b0;
                    out_last_reg  <= emit_last;
                    if (i_reg == c_reg[1] - 7'd1)
                    begin
                        i_reg    <= 7'd0;
                        p_reg[1] <= o_reg[1];
                        j_reg    <= j_reg + 7'd1;
                        p_reg[0] <= p_reg[0] + w0;
                    end
                    else
                    begin
                        i_reg    <= i_reg + 7'd1;
                        p_reg[1] <= p_reg[1] + w1;
                    end
                end
            end
            OP_EMPTY:
            begin
                if (out_free)
                begin
                    out_lo0_reg   <= 32'd0;
                    out_hi0_reg   <= 32'd0;
                    out_lo1_reg   <= 32'd0;
                    out_hi1_reg   <= 32'd0;
                    out_empty_reg <= 1'b1;
                    out_last_reg  <= 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Channel outputs.
    assign req.ready       = cmd.op == OP_LOAD;
    assign chunk.valid     = out_valid_reg;
    assign chunk.chunk_lo0 = out_lo0_reg;
    assign chunk.chunk_hi0 = out_hi0_reg;
    assign chunk.chunk_lo1 = out_lo1_reg;
    assign chunk.chunk_hi1 = out_hi1_reg;
    assign chunk.empty_res = out_empty_reg;
    assign chunk.last      = out_last_reg;

    // An empty result is the last of its request and carries zero coordinates.
    `BCS_ASSERT_IMPL(a_empty_shape, out_valid_reg && out_empty_reg,
        out_last_reg && out_lo0_reg == 32'd0 && out_hi1_reg == 32'd0, "empty result malformed")
    // The best product found never exceeds the requested count.
    `BCS_ASSERT_IMPL(a_best_bounded, 1'b1, bprod_reg <= 14'(n_reg), "best count above request")
    // Emission stays inside the chunk grid with a sane large-chunk count.
    `BCS_ASSERT_IMPL(a_emit_range, cmd.op == OP_EMIT,
        j_reg < c_reg[0] && nl_reg[0] <= c_reg[0], "emission outside grid")
    // A latched request count is saturated.
    `BCS_ASSERT_NEXT(a_n_saturated, accept, n_reg <= CHUNK_CAP, "request count not saturated")

endmodule

// ----- design/box_chunk_splitter.sv -----
// Box chunk splitter: takes one box per request transaction, emits one chunk per cycle
// while the sink is ready. Work per request: two 32-bit divisions, then in 2D mode the
// near-square test and up to 4 divisions per factor pair tried, then 3 or 6 for sizing.
// Throughput: one request at a time; chunks leave at one per cycle while the sink is ready.
// Reset (rst_n, asynchronous, active low) sets the requested chunk count to 1 and empties
// the output. Depends on bcs_pkg, the channel interfaces, bcs_ctrl and bcs_datapath.
`timescale 1ns / 1ps

module box_chunk_splitter
    import bcs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [6:0]  cfg_wdata,
    bcs_req_if.sink     req,
    bcs_chunk_if.source chunk
);

    cmd_t cmd;
    sts_t sts;

    // Sequencer.
    bcs_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    // Arithmetic and output stage.
    bcs_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sts       (sts),
        .req       (req),
        .chunk     (chunk)
    );

endmodule

// ----- tb/bcs_checker.sv -----
// Checker for the box chunk splitter: watches the configuration port and both channels.
// Depends on bcs_pkg and the channel interfaces; predicts chunks and compares them.
`timescale 1ns / 1ps

module bcs_checker
    import bcs_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  cfg_we,
    input  logic [6:0] cfg_wdata,
    bcs_req_if    req,
    bcs_chunk_if  chunk,
    output int    errors,
    output int    pending
);

    typedef struct packed {
        logic [31:0] lo0;
        logic [31:0] hi0;
        logic [31:0] lo1;
        logic [31:0] hi1;
        logic        empty;
        logic        last;
    } chunk_t;

    chunk_t      chunks_due[$];
    logic [6:0]  split_count;

    assign pending = chunks_due.size();

    // Print one line per mismatch and count it.
    task automatic report(input string what, input logic [31:0] want, input logic [31:0] got);
        $display("mismatch %s: expected %h, got %h at %0t", what, want, got, $realtime);
        errors++;
    endtask

    function automatic logic [63:0] min64(input logic [63:0] a, input logic [63:0] b);
        return (a < b) ? a : b;
    endfunction

    // Give a factor pair to the two dimensions in the order that yields more chunks, ties broken by shape.
    function automatic void place_pair(input logic [63:0] f0, input logic [63:0] f1,
                                       input logic [63:0] e0, input logic [63:0] e1,
                                       input logic near_sq, input logic [63:0] m0,
                                       input logic [63:0] m1, output logic [63:0] c0,
                                       output logic [63:0] c1);
        logic [63:0] a0, a1, b0, b1, n01, n10;
        logic        keep;
        a0 = min64(f0, m0);
        a1 = min64(f1, m1);
        b0 = min64(f1, m0);
        b1 = min64(f0, m1);
        n01 = a0 * a1;
        n10 = b0 * b1;
        if (n01 != n10) begin
            keep = n01 > n10;
        end
        else if (n01 == 0) begin
            keep = 1'b1;
        end
        else if (near_sq) begin
            keep = f0 >= f1;
        end
        else begin
            keep = (e0 / a0 + e1 / a1) < (e0 / b0 + e1 / b1);
        end
        c0 = keep ? a0 : b0;
        c1 = keep ? a1 : b1;
    endfunction

    // Work out every chunk of one request and queue them in emission order.
    function automatic void split_box(input logic mode2d, input logic [31:0] o0,
                                      input logic [31:0] o1, input logic [31:0] x0,
                                      input logic [31:0] x1, input logic [31:0] x2,
                                      input logic [31:0] g0, input logic [31:0] g1);
        logic [63:0]  n, m0, m1, c0, c1, bc0, bc1, t0, t1, f;
        logic [63:0]  e0, e1, ideal, sm0, sm1, nl0, nl1, w0, w1;
        logic [127:0] area, sq;
        logic [31:0]  p0, p1, hi1;
        logic         near_sq;
        chunk_t       c;
        n = (split_count > CHUNK_CAP) ? 64'(CHUNK_CAP) : 64'(split_count);
        e0 = 64'(x0);
        e1 = 64'(x1);
        m0 = (g0 != 0) ? e0 / g0 : 0;
        m1 = (g1 != 0) ? e1 / g1 : 0;
        area = 128'(x0) * 128'(x1) * 128'(x2) * 128'(NEAR_MID);
        sq = 128'(x0) * 128'(x0);
        near_sq = (sq * NEAR_LO < area) && (area < sq * NEAR_HI);
        c0 = 0;
        c1 = 1;
        if (!mode2d) begin
            c0 = min64(n, m0);
        end
        else if (n > 0) begin
            bc0 = 0;
            bc1 = 0;
            f = 1;
            while ((f + 1) * (f + 1) <= n) f++;
            while (f >= 1) begin
                while (f > 1 && n % f != 0) f--;
                place_pair(f, n / f, e0, e1, near_sq, m0, m1, t0, t1);
                if (t0 * t1 > bc0 * bc1) begin
                    bc0 = t0;
                    bc1 = t1;
                end
                if (t0 * t1 == n) break;
                f--;
            end
            c0 = bc0;
            c1 = bc1;
        end
        if (c0 * c1 == 0) begin
            c = '0;
            c.empty = 1'b1;
            c.last = 1'b1;
            chunks_due.push_back(c);
            return;
        end
        ideal = e0 / c0;
        sm0 = (ideal / g0) * g0;
        nl0 = min64((e0 - sm0 * c0) / g0, c0);
        sm1 = 0;
        nl1 = 0;
        if (mode2d) begin
            ideal = e1 / c1;
            sm1 = (ideal / g1) * g1;
            nl1 = min64((e1 - sm1 * c1) / g1, c1);
        end
        p0 = o0;
        for (longint j = 0; j < c0; j++) begin
            w0 = (j < nl0) ? sm0 + g0 : sm0;
            p1 = o1;
            for (longint i = 0; i < c1; i++) begin
                if (mode2d) begin
                    w1 = (i < nl1) ? sm1 + g1 : sm1;
                    hi1 = p1 + w1[31:0];
                end
                else begin
                    w1 = 0;
                    hi1 = o1 + x1;
                end
                c.lo0 = p0;
                c.hi0 = p0 + w0[31:0];
                c.lo1 = p1;
                c.hi1 = hi1;
                c.empty = 1'b0;
                c.last = (j + 1 == c0) && (i + 1 == c1);
                chunks_due.push_back(c);
                p1 = p1 + w1[31:0];
            end
            p0 = p0 + w0[31:0];
        end
    endfunction

    initial errors = 0;

    // Track the register, predict on each request and compare each chunk.
    always @(posedge clk or negedge rst_n)
    begin
        chunk_t want;
        if (!rst_n) begin
            split_count <= 7'd1;
        end
        else begin
            if (cfg_we) begin
                split_count <= cfg_wdata;
            end
            if (req.valid && req.ready) begin
                split_box(req.func, req.origin0, req.origin1, req.extent0, req.extent1,
                          req.extent2, req.gran0, req.gran1);
            end
            if (chunk.valid && chunk.ready) begin
                if (chunks_due.size() == 0) begin
                    report("unexpected chunk lo0", 32'h0, chunk.chunk_lo0);
                end
                else begin
                    want = chunks_due.pop_front();
                    if (chunk.chunk_lo0 !== want.lo0) report("lo0", want.lo0, chunk.chunk_lo0);
                    if (chunk.chunk_hi0 !== want.hi0) report("hi0", want.hi0, chunk.chunk_hi0);
                    if (chunk.chunk_lo1 !== want.lo1) report("lo1", want.lo1, chunk.chunk_lo1);
                    if (chunk.chunk_hi1 !== want.hi1) report("hi1", want.hi1, chunk.chunk_hi1);
                    if (chunk.empty_res !== want.empty) begin
                        report("empty_res", 32'(want.empty), 32'(chunk.empty_res));
                    end
                    if (chunk.last !== want.last) begin
                        report("last", 32'(want.last), 32'(chunk.last));
                    end
                end
            end
        end
    end

endmodule

// ----- tb/box_chunk_splitter_tb.sv -----
// Top of the box chunk splitter testbench: clock, reset, stimulus and the verdict.
// Depends on bcs_pkg, the channel interfaces, box_chunk_splitter and bcs_checker.
`timescale 1ns / 1ps

module box_chunk_splitter_tb;
    import bcs_pkg::*;

    localparam int STALL_LIMIT = 40000;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic [6:0] cfg_wdata;
    int         errors;
    int         pending;
    int         send_idle_pct;
    int         recv_stall_pct;
    int         quiet_cycles;

    bcs_req_if   req ();
    bcs_chunk_if chunk ();

    box_chunk_splitter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .chunk     (chunk)
    );

    bcs_checker checker_i (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req),
        .chunk     (chunk),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver stalls at random at the configured rate.
    always @(negedge clk)
    begin
        chunk.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: too long with work outstanding and no transaction ends the run.
    always @(posedge clk)
    begin
        if ((req.valid && req.ready) || (chunk.valid && chunk.ready)
            || (pending == 0 && !req.valid)) begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
        else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Present one request and hold it until the block takes it.
    task automatic send(input logic f, input logic [31:0] o0, input logic [31:0] o1,
                        input logic [31:0] e0, input logic [31:0] e1, input logic [31:0] e2,
                        input logic [31:0] g0, input logic [31:0] g1);
        while ($urandom_range(99) < send_idle_pct) begin
            req.valid <= 1'b0;
            @(negedge clk);
        end
        req.valid <= 1'b1;
        req.func <= f;
        req.origin0 <= o0;
        req.origin1 <= o1;
        req.extent0 <= e0;
        req.extent1 <= e1;
        req.extent2 <= e2;
        req.gran0 <= g0;
        req.gran1 <= g1;
        do @(posedge clk); while (!req.ready);
        @(negedge clk);
    endtask

    function automatic logic [31:0] rand_gran();
        logic [31:0] g;
        case ($urandom_range(3))
            0: g = 1;
            1: g = $urandom_range(1, 16);
            2: g = $urandom;
            default: g = 32'd1 << $urandom_range(31);
        endcase
        return (g == 0) ? 32'd1 : g;
    endfunction

    function automatic logic [31:0] rand_extent(input logic [31:0] g);
        if ($urandom_range(7) == 0) return $urandom;
        if ($urandom_range(3) == 0) return g * $urandom_range(0, 2);
        return g * $urandom_range(1, 80);
    endfunction

    // One random request, mostly well-formed multiples of the granularity.
    task automatic send_random();
        logic [31:0] g0, g1, e0, e1, e2;
        g0 = rand_gran();
        g1 = ($urandom_range(2) == 0) ? g0 : rand_gran();
        e0 = rand_extent(g0);
        e1 = ($urandom_range(3) == 0) ? e0 : rand_extent(g1);
        case ($urandom_range(2))
            0: e2 = 1;
            1: e2 = $urandom_range(0, 4);
            default: e2 = $urandom;
        endcase
        send($urandom_range(1), $urandom, $urandom, e0, e1, e2, g0, g1);
    endtask

    // Wait until every chunk has arrived, then let the block settle before a write.
    task automatic drain_and_set(input logic [6:0] count);
        req.valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= count;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Stimulus: directed requests, then random phases with varied counts and idling.
    initial
    begin
        logic [6:0] counts [8];
        counts = '{7'd12, 7'd1, 7'd64, 7'd7, 7'd36, 7'd2, 7'd60, 7'd5};
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        req.valid = 1'b0;
        req.func = 1'b0;
        req.origin0 = '0;
        req.origin1 = '0;
        req.extent0 = '0;
        req.extent1 = '0;
        req.extent2 = '0;
        req.gran0 = 32'd1;
        req.gran1 = 32'd1;
        chunk.ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        quiet_cycles = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset count of one, then a count with several factor pairs.
        send(1'b1, 32'd5, 32'd9, 32'd40, 32'd40, 32'd1, 32'd4, 32'd4);
        drain_and_set(7'd12);
        send(1'b0, 32'd0, 32'd0, 32'd0, 32'd7, 32'd1, 32'd1, 32'd1);
        send(1'b1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1, 32'd1, 32'd1);
        send(1'b0, 32'd100, 32'd3, 32'd120, 32'd55, 32'd1, 32'd10, 32'd1);
        send(1'b0, 32'd100, 32'd3, 32'd125, 32'd55, 32'd1, 32'd10, 32'd1);
        send(1'b0, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'd50, 32'hFFFF_FFFF, 32'd1, 32'd1, 32'd1);
        send(1'b1, 32'd0, 32'd0, 32'd120, 32'd120, 32'd1, 32'd1, 32'd1);
        send(1'b1, 32'd7, 32'd7, 32'd1200, 32'd120, 32'd1, 32'd10, 32'd10);
        send(1'b1, 32'd7, 32'd7, 32'd120, 32'd1200, 32'd1, 32'd10, 32'd10);
        send(1'b1, 32'd0, 32'd0, 32'd3, 32'd100, 32'd1, 32'd1, 32'd1);
        send(1'b1, 32'd0, 32'd0, 32'd100, 32'd2, 32'd1, 32'd1, 32'd1);
        send(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
             32'hFFFF_FFFF, 32'd1, 32'd1);
        send(1'b1, 32'd1, 32'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0,
             32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send(1'b1, 32'd0, 32'd0, 32'd60, 32'd70, 32'd1, 32'd1, 32'd1);
        send(1'b1, 32'd0, 32'd0, 32'd60, 32'd10, 32'd6, 32'd1, 32'd1);
        send(1'b1, 32'd0, 32'd0, 32'd130, 32'd125, 32'd1, 32'd10, 32'd5);
        send(1'b0, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'd1);

        // Random phases: each idling mode appears twice with a different count.
        for (int ph = 0; ph < 8; ph++) begin
            drain_and_set(counts[ph]);
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
                default: begin send_idle_pct = 28; recv_stall_pct = 28; end
            endcase
            repeat (18) send_random();
        end
        req.valid <= 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (50) @(negedge clk);
        if (errors == 0) begin
            $display("TB_OK");
        end
        else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+design
design/bcs_pkg.sv
design/bcs_ifs.sv
design/bcs_div.sv
design/bcs_ctrl.sv
design/bcs_datapath.sv
design/box_chunk_splitter.sv
tb/bcs_checker.sv
tb/box_chunk_splitter_tb.sv
